### sv/ansi_escape_sequence_parser_core_macros.svh
// ----------------------------------------------------------------------------
// ANSI escape sequence parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ANSI_ESCAPE_SEQUENCE_PARSER_CORE_MACROS_SVH
`define ANSI_ESCAPE_SEQUENCE_PARSER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define AESP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("aesp assertion failed");

// next-cycle implication, off during reset
`define AESP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("aesp assertion failed");

`endif

### sv/aesp_pkg.sv
// ----------------------------------------------------------------------------
// ANSI escape sequence parser package
// Request and result types, phase codes and character constants.
// ----------------------------------------------------------------------------
package aesp_pkg;

  typedef struct packed {
    logic [7:0] char_in;
  } aesp_req_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] first_number;
    logic [15:0] second_number;
    logic [7:0]  final_char;
    logic        ss3_intro;
  } aesp_res_t;

  localparam logic [2:0] PH_NONE    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_BRACKET = 3'd2;
  localparam logic [2:0] PH_NUM1    = 3'd3;
  localparam logic [2:0] PH_NUM2    = 3'd4;
  localparam logic [2:0] PH_FINAL   = 3'd5;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SS3      = 8'h4F;
  localparam logic [7:0] CH_RIS      = 8'h63;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

  localparam logic [15:0] NUM_MAX = 16'hFFFF;

  // acc * 10 + digit, saturated to 16 bits
  function automatic logic [15:0] add_digit(logic [15:0] acc, logic [3:0] dig);
    logic [19:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {16'b0, dig};
    return (v > {4'b0, NUM_MAX}) ? NUM_MAX : v[15:0];
  endfunction

endpackage

### sv/aesp_stream_if.sv
// ----------------------------------------------------------------------------
// ANSI escape sequence parser stream interface
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface aesp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/ansi_escape_sequence_parser_core.sv
// ----------------------------------------------------------------------------
// ANSI escape sequence parser core
// Parses VT100/ANSI escape sequences one character per request.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload     Handshake
// char_i   in   aesp_req_t  valid/ready, one character per request
// res_o    out  aesp_res_t  valid/ready, one result per request
//
// One request per cycle when not stalled; a result follows in the next cycle.
// The parse state and the result register update in the same cycle.
// A held result stalls input only while res_o is not ready.
// Reset clears the phase, counter, numbers and output valid.
// ----------------------------------------------------------------------------
`include "ansi_escape_sequence_parser_core_macros.svh"

module ansi_escape_sequence_parser_core #(
  parameter int MAX_SEQ_CHARS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  aesp_stream_if.sink          char_i,
  aesp_stream_if.source        res_o
);
  import aesp_pkg::*;

  localparam int CntW = $clog2(MAX_SEQ_CHARS + 2);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_SEQ_CHARS);

  logic [2:0]      phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     num1_q, num1_d;
  logic [15:0]     num2_q, num2_d;
  logic [7:0]      final_q, final_d;
  logic            ss3_q, ss3_d;
  logic            valid_q;
  aesp_res_t       res_q;

  logic [7:0]      ch;
  logic [CntW-1:0] cnt_inc;
  logic            clr;
  logic            is_dig;
  logic            is_term;
  logic            accept;

  assign ch      = char_i.payload.char_in;
  assign accept  = char_i.valid && char_i.ready;
  assign char_i.ready = !valid_q || res_o.ready;

  always_comb begin
    cnt_inc = count_q + 1'b1;
    clr     = (phase_q == PH_FINAL) || (cnt_inc > CntMax);
    is_dig  = ch inside {[8'h30:8'h39]};
    is_term = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (ch == CH_TILDE);

    phase_d = clr ? PH_NONE : phase_q;
    count_d = clr ? '0 : cnt_inc;
    num1_d  = clr ? '0 : num1_q;
    num2_d  = clr ? '0 : num2_q;
    final_d = clr ? '0 : final_q;
    ss3_d   = clr ? 1'b0 : ss3_q;

    if (phase_d == PH_NONE && ch == CH_ESC) begin
      phase_d = PH_ESC;
    end else if (phase_d == PH_ESC && ch == CH_LBRACKET) begin
      phase_d = PH_BRACKET;
    end else if (phase_d == PH_ESC && ch == CH_SS3) begin
      ss3_d   = 1'b1;
      phase_d = PH_BRACKET;
    end else if (phase_d == PH_ESC && ch == CH_RIS) begin
      final_d = ch;
      phase_d = PH_FINAL;
    end else if (phase_d == PH_BRACKET && is_dig) begin
      num1_d  = {12'b0, ch[3:0]};
      phase_d = PH_NUM1;
    end else if (phase_d == PH_NUM1 && is_dig) begin
      num1_d = add_digit(num1_d, ch[3:0]);
    end else if (phase_d == PH_NUM1 && ch == CH_SEMI) begin
      num2_d  = '0;
      phase_d = PH_NUM2;
    end else if (phase_d == PH_NUM2 && is_dig) begin
      num2_d = add_digit(num2_d, ch[3:0]);
    end else if (phase_d > PH_ESC && phase_d < PH_FINAL && is_term) begin
      final_d = ch;
      phase_d = PH_FINAL;
    end else begin
      // drop the sequence, keep stale parameters
      count_d = '0;
      phase_d = PH_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NONE;
      count_q <= '0;
      num1_q  <= '0;
      num2_q  <= '0;
      final_q <= '0;
      ss3_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        count_q <= count_d;
        num1_q  <= num1_d;
        num2_q  <= num2_d;
        final_q <= final_d;
        ss3_q   <= ss3_d;
        valid_q <= 1'b1;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q.phase         <= phase_d;
      res_q.first_number  <= num1_d;
      res_q.second_number <= num2_d;
      res_q.final_char    <= final_d;
      res_q.ss3_intro     <= ss3_d;
    end
  end

  assign res_o.valid   = valid_q;
  assign res_o.payload = res_q;

  `AESP_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntMax)
  `AESP_ASSERT_NOW(a_none_count_zero, clk_i, rst_ni, phase_q == PH_NONE, count_q == '0)
  `AESP_ASSERT_NEXT(a_result_tracks_state, clk_i, rst_ni, accept, valid_q && res_q.phase == phase_q && res_q.first_number == num1_q)
  `AESP_ASSERT_NEXT(a_final_restarts, clk_i, rst_ni, accept && phase_q == PH_FINAL, phase_q == PH_NONE || phase_q == PH_ESC)

endmodule

### dv/ansi_escape_sequence_parser_core_test.sv
// ----------------------------------------------------------------------------
// ANSI escape sequence parser core testbench
// Streams characters into the parser and checks every result against a
// cycle-free model of the VT100 parse phases, parameters and flags. A short
// directed run is followed by random escape sequences, broken sequences and
// noise, in three segments with different sender and receiver idle rates.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aesp_pkg::*;

  localparam int          SEQ_LIMIT     = 16;
  localparam int unsigned SEGMENT_CHARS = 575;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned PRINT_LIMIT   = 200;

  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  aesp_stream_if #(.payload_t(aesp_req_t)) char_if ();
  aesp_stream_if #(.payload_t(aesp_res_t)) res_if ();

  logic      req_valid = 1'b0;
  aesp_req_t req_item  = '0;
  logic      res_ready = 1'b0;

  assign char_if.valid   = req_valid;
  assign char_if.payload = req_item;
  assign res_if.ready    = res_ready;

  ansi_escape_sequence_parser_core #(
    .MAX_SEQ_CHARS(SEQ_LIMIT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(char_if),
    .res_o (res_if)
  );

  logic [7:0]  char_backlog[$];
  aesp_res_t   expected_results[$];
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 79;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;

  logic [2:0]  cur_phase  = PH_NONE;
  int unsigned seq_len    = 0;
  logic [15:0] arg_first  = '0;
  logic [15:0] arg_second = '0;
  logic [7:0]  term_char  = '0;
  logic        ss3_seen   = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [15:0] append_digit(logic [15:0] acc, logic [7:0] c);
    int unsigned v;
    v = acc * 10 + (c - CH_DIGIT0);
    return (v > NUM_MAX) ? NUM_MAX : v[15:0];
  endfunction

  function automatic aesp_res_t parse_char(logic [7:0] c);
    aesp_res_t r;
    logic      is_dig;
    logic      is_term;
    is_dig  = (c >= CH_DIGIT0) && (c <= CH_DIGIT9);
    is_term = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
              (c == CH_TILDE);
    seq_len++;
    if (cur_phase == PH_FINAL || seq_len > SEQ_LIMIT) begin
      cur_phase  = PH_NONE;
      seq_len    = 0;
      arg_first  = '0;
      arg_second = '0;
      term_char  = '0;
      ss3_seen   = 1'b0;
    end
    if (cur_phase == PH_NONE && c == CH_ESC) begin
      cur_phase = PH_ESC;
    end else if (cur_phase == PH_ESC && c == CH_LBRACKET) begin
      cur_phase = PH_BRACKET;
    end else if (cur_phase == PH_ESC && c == CH_SS3) begin
      ss3_seen  = 1'b1;
      cur_phase = PH_BRACKET;
    end else if (cur_phase == PH_ESC && c == CH_RIS) begin
      term_char = c;
      cur_phase = PH_FINAL;
    end else if (cur_phase == PH_BRACKET && is_dig) begin
      arg_first = {8'h00, c - CH_DIGIT0};
      cur_phase = PH_NUM1;
    end else if (cur_phase == PH_NUM1 && is_dig) begin
      arg_first = append_digit(arg_first, c);
    end else if (cur_phase == PH_NUM1 && c == CH_SEMI) begin
      arg_second = '0;
      cur_phase  = PH_NUM2;
    end else if (cur_phase == PH_NUM2 && is_dig) begin
      arg_second = append_digit(arg_second, c);
    end else if (cur_phase > PH_ESC && cur_phase < PH_FINAL && is_term) begin
      term_char = c;
      cur_phase = PH_FINAL;
    end else begin
      seq_len   = 0;
      cur_phase = PH_NONE;
    end
    r.phase         = cur_phase;
    r.first_number  = arg_first;
    r.second_number = arg_second;
    r.final_char    = term_char;
    r.ss3_intro     = ss3_seen;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("[%0t] result %0d: %s", $time, results_seen, msg);
    end
    mismatches++;
  endtask

  function automatic logic [7:0] random_digit();
    return CH_DIGIT0 + 8'($urandom_range(9));
  endfunction

  task automatic add_random_chars(int unsigned count);
    logic [7:0]  seq[$];
    int unsigned added;
    int unsigned kind;
    int unsigned k;
    int unsigned n1;
    int unsigned n2;
    added = 0;
    while (added < count) begin
      seq.delete();
      kind = $urandom_range(99);
      if (kind < 85) begin
        seq.push_back(CH_ESC);
        k = $urandom_range(9);
        if (k == 9) begin
          seq.push_back(8'($urandom_range(255)));
        end else if (k == 8) begin
          seq.push_back(CH_RIS);
        end else begin
          seq.push_back(k < 6 ? CH_LBRACKET : CH_SS3);
          n1 = ($urandom_range(9) == 0) ? $urandom_range(14, 4) : $urandom_range(3, 0);
          repeat (n1) seq.push_back(random_digit());
          if (n1 != 0 && $urandom_range(1) == 1) begin
            seq.push_back(CH_SEMI);
            n2 = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 0);
            repeat (n2) seq.push_back(random_digit());
          end
          case ($urandom_range(2))
            0: seq.push_back(CH_TILDE);
            1: seq.push_back(CH_UP_A + 8'($urandom_range(25)));
            default: seq.push_back(CH_LO_A + 8'($urandom_range(25)));
          endcase
        end
        if (kind >= 70) begin
          k = $urandom_range(seq.size() - 1);
          if ($urandom_range(1) == 1) begin
            seq[k] = 8'($urandom_range(255));
          end else begin
            while (seq.size() > k + 1) void'(seq.pop_back());
          end
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          seq.push_back($urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32)));
        end
      end
      foreach (seq[i]) char_backlog.push_back(seq[i]);
      added += seq.size();
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (char_backlog.size() != 0 || req_valid || expected_results.size() != 0);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req_item  <= '0;
    end else if (!req_valid || char_if.ready) begin
      if (char_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_valid         <= 1'b1;
        req_item.char_in  <= char_backlog.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    logic      progress;
    aesp_res_t got;
    aesp_res_t want;
    if (rst_ni) begin
      progress = 1'b0;
      if (char_if.valid && char_if.ready) begin
        expected_results.push_back(parse_char(char_if.payload.char_in));
        progress = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        progress = 1'b1;
        got      = res_if.payload;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          if (got.phase !== want.phase)
            report_mismatch($sformatf("phase got %0d expected %0d", got.phase, want.phase));
          if (got.first_number !== want.first_number)
            report_mismatch($sformatf("first_number got %0d expected %0d",
                                      got.first_number, want.first_number));
          if (got.second_number !== want.second_number)
            report_mismatch($sformatf("second_number got %0d expected %0d",
                                      got.second_number, want.second_number));
          if (got.final_char !== want.final_char)
            report_mismatch($sformatf("final_char got %h expected %h",
                                      got.final_char, want.final_char));
          if (got.ss3_intro !== want.ss3_intro)
            report_mismatch($sformatf("ss3_intro got %b expected %b",
                                      got.ss3_intro, want.ss3_intro));
        end
        results_seen++;
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [7:0] directed[];
    directed = '{
      CH_ESC, CH_LBRACKET, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, CH_SEMI,
      8'h37, 8'h30, 8'h30, 8'h30, 8'h30, CH_TILDE,
      CH_ESC, CH_RIS,
      CH_ESC, CH_SS3, 8'h50,
      8'h00, 8'hFF,
      CH_ESC, CH_ESC,
      CH_ESC, CH_LBRACKET, 8'h7A
    };
    foreach (directed[i]) char_backlog.push_back(directed[i]);
    add_random_chars(SEGMENT_CHARS);
    wait_drained();
    send_idle_pct = 79;
    recv_idle_pct = 30;
    add_random_chars(SEGMENT_CHARS);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_chars(SEGMENT_CHARS);
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
